// ===== rtl/core/ztpr_pkg.sv =====
// ----------------------------------------------------------------------------
// ztpr_pkg
// Types, constants and the palette lookup shared by the zoomed tilemap
// pixel renderer and its port checker.
// ----------------------------------------------------------------------------
package ztpr_pkg;

	localparam int GRID_W       = 256;
	localparam int GRID_H       = 128;
	localparam int REGION_COUNT = 200;
	localparam int NO_REGION    = 255;

	localparam int MAP_DEPTH  = 32768;
	localparam int ADDR_W     = 15;
	localparam int ID_W       = 8;
	localparam int COLOR_W    = 16;
	localparam int FRAC_BITS  = 17;
	localparam int PIX_W      = 10;
	localparam int VIEW_W     = 11;
	localparam int CX_W       = 24;
	localparam int CY_W       = 23;
	localparam int INV_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// half-pixel offset, its product with the inverse scale, grid coordinate
	localparam int D_W    = PIX_W + 2;
	localparam int PROD_W = D_W + INV_W + 1;
	localparam int G_W    = PROD_W + 1;
	localparam int CELL_W = G_W - FRAC_BITS;

	localparam logic [COLOR_W-1:0] OCEAN_COLOR = 16'h21AD;
	localparam logic [COLOR_W-1:0] GRID_COLOR  = 16'h4208;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_INV_SCALE   = 3'd2,
		REG_VIEW_WIDTH  = 3'd3,
		REG_VIEW_HEIGHT = 3'd4,
		REG_SHOW_GRID   = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_RENDER = 1'b1
	} opcode_t;

	// colour for an id whose remainder mod 12 is r: palette[(7*r + 3) mod 12]
	function automatic logic [COLOR_W-1:0] color_of_rem(input logic [3:0] r);
		logic [COLOR_W-1:0] c;
		case (r)
			4'd0:    c = 16'hB430;
			4'd1:    c = 16'hAD75;
			4'd2:    c = 16'h95B5;
			4'd3:    c = 16'h9D70;
			4'd4:    c = 16'h95CE;
			4'd5:    c = 16'h8D56;
			4'd6:    c = 16'h8CF8;
			4'd7:    c = 16'hA4D7;
			4'd8:    c = 16'hBCEA;
			4'd9:    c = 16'hC5EC;
			4'd10:   c = 16'hC50B;
			4'd11:   c = 16'hB515;
			default: c = OCEAN_COLOR;
		endcase
		return c;
	endfunction

	// id mod 12 for an 8-bit id: quotient by reciprocal 171/2048, exact below 256
	function automatic logic [3:0] rem12(input logic [ID_W-1:0] id);
		logic [16:0] prod;
		logic [4:0]  q;
		logic [8:0]  r;
		prod = 17'(id) * 17'd171;
		q    = prod[15:11];
		r    = 9'(id) - 9'(q) * 9'd12;
		return r[3:0];
	endfunction

endpackage

// ===== rtl/core/zoomed_tilemap_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// zoomed_tilemap_pixel_renderer
// Maps a screen pixel through a zoomed, panned camera onto a region map and
// returns its RGB565 colour; load requests fill the map store.
//
//   channel  signals                                   dir   role
//   in       in_valid/in_ready, opcode, pixel_x,       in    load or render
//            pixel_y, cell_index, region_id
//   out      out_valid/out_ready, pixel_color          out   rendered colour
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data  in    register write
//
// One request per cycle while out is not stalled; a render request shows its
// colour on out from the colour stage, a load request returns nothing.
// Stages: offset, multiply, grid add and bounds, map read, colour.
// The map store is a single-port memory shared by loads and reads in order.
// A stall on out freezes every stage; reset clears the valid bits and
// restores the register defaults.
// ----------------------------------------------------------------------------
module zoomed_tilemap_pixel_renderer
	import ztpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  opcode,
	input  logic [PIX_W-1:0]      pixel_x,
	input  logic [PIX_W-1:0]      pixel_y,
	input  logic [ADDR_W-1:0]     cell_index,
	input  logic [ID_W-1:0]       region_id,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [COLOR_W-1:0]    pixel_color,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [CX_W-1:0]   center_x_q;
	logic [CY_W-1:0]   center_y_q;
	logic [INV_W-1:0]  inv_scale_q;
	logic [VIEW_W-1:0] view_width_q;
	logic [VIEW_W-1:0] view_height_q;
	logic              show_grid_q;

	logic adv;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;
	opcode_t                  op_s1, op_s2, op_s3, op_s4;
	logic signed [D_W-1:0]    dx_s1, dy_s1;
	logic [ADDR_W-1:0]        cidx_s1, cidx_s2;
	logic [ID_W-1:0]          rid_s1, rid_s2, rid_s3;
	logic signed [PROD_W-1:0] px_s2, py_s2;
	logic [ADDR_W-1:0]        addr_s3;
	logic                     land_s3, line_s3;
	logic                     land_s4, line_s4;
	logic [ID_W-1:0]          rd_s4;
	logic [COLOR_W-1:0]       color_s5;

	logic signed [G_W-1:0] gx, gy;
	logic [CELL_W-1:0]     cell_x, cell_y;
	logic [INV_W:0]        line_w;
	logic                  in_grid, on_line;
	logic [ADDR_W-1:0]     cell_addr;
	logic [COLOR_W-1:0]    color;

	logic [ID_W-1:0] map_mem [MAP_DEPTH];

	assign adv       = !v_s5 || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= CX_W'(24'h800000);
			center_y_q    <= CY_W'(23'h400000);
			inv_scale_q   <= INV_W'(24'd52429);
			view_width_q  <= VIEW_W'(11'd320);
			view_height_q <= VIEW_W'(11'd240);
			show_grid_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_CENTER_X:    center_x_q    <= cfg_data[CX_W-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_data[CY_W-1:0];
				REG_INV_SCALE:   inv_scale_q   <= cfg_data[INV_W-1:0];
				REG_VIEW_WIDTH:  view_width_q  <= cfg_data[VIEW_W-1:0];
				REG_VIEW_HEIGHT: view_height_q <= cfg_data[VIEW_W-1:0];
				REG_SHOW_GRID:   show_grid_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4 && (op_s4 == OP_RENDER);
		end
	end

	// grid coordinate, bounds and line test
	always_comb begin
		line_w    = {inv_scale_q, 1'b0};
		gx        = $signed(G_W'({center_x_q, 1'b0})) + G_W'(px_s2);
		gy        = $signed(G_W'({center_y_q, 1'b0})) + G_W'(py_s2);
		cell_x    = CELL_W'(gx >>> FRAC_BITS);
		cell_y    = CELL_W'(gy >>> FRAC_BITS);
		in_grid   = !gx[G_W-1] && !gy[G_W-1] &&
			(cell_x < CELL_W'(GRID_W)) && (cell_y < CELL_W'(GRID_H));
		on_line   = show_grid_q && ((25'(gx[FRAC_BITS-1:0]) < line_w) ||
			(25'(gy[FRAC_BITS-1:0]) < line_w));
		cell_addr = ADDR_W'(cell_y * CELL_W'(GRID_W) + cell_x);
	end

	// colour selection
	always_comb begin
		color = OCEAN_COLOR;
		if (land_s4 && rd_s4 != ID_W'(NO_REGION)) begin
			if (rd_s4 < ID_W'(REGION_COUNT))
				color = color_of_rem(rem12(rd_s4));
			if (line_s4)
				color = GRID_COLOR;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1   <= opcode_t'(opcode);
			dx_s1   <= $signed({1'b0, pixel_x, 1'b1}) - $signed({1'b0, view_width_q});
			dy_s1   <= $signed({1'b0, pixel_y, 1'b1}) - $signed({1'b0, view_height_q});
			cidx_s1 <= cell_index;
			rid_s1  <= region_id;

			op_s2   <= op_s1;
			px_s2   <= PROD_W'(dx_s1) * PROD_W'($signed({1'b0, inv_scale_q}));
			py_s2   <= PROD_W'(dy_s1) * PROD_W'($signed({1'b0, inv_scale_q}));
			cidx_s2 <= cidx_s1;
			rid_s2  <= rid_s1;

			op_s3   <= op_s2;
			addr_s3 <= (op_s2 == OP_RENDER) ? cell_addr : cidx_s2;
			land_s3 <= in_grid;
			line_s3 <= on_line;
			rid_s3  <= rid_s2;

			op_s4   <= op_s3;
			land_s4 <= land_s3;
			line_s4 <= line_s3;

			color_s5 <= color;
		end
	end

	// map store
	always_ff @(posedge clk) begin
		if (adv && v_s3) begin
			if (op_s3 == OP_WRITE)
				map_mem[addr_s3] <= rid_s3;
			else
				rd_s4 <= map_mem[addr_s3];
		end
	end

	assign out_valid   = v_s5;
	assign pixel_color = color_s5;

endmodule

// ===== rtl/core/ztpr_checker.sv =====
// ----------------------------------------------------------------------------
// ztpr_checker
// Port-level checks on the zoomed tilemap pixel renderer, bound to the top.
// ----------------------------------------------------------------------------
module ztpr_checker
	import ztpr_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  opcode,
	input logic [PIX_W-1:0]      pixel_x,
	input logic [PIX_W-1:0]      pixel_y,
	input logic [ADDR_W-1:0]     cell_index,
	input logic [ID_W-1:0]       region_id,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [COLOR_W-1:0]    pixel_color,
	input logic                  cfg_valid,
	input logic                  cfg_ready,
	input logic [CFG_IDX_W-1:0]  cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	// a request is taken whenever the output side can move
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow output stall");

	// a held colour stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_color))
		else $error("output request dropped or changed while stalled");

	// a colour only leaves by being taken
	a_out_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("output request withdrawn");

	// register writes are never stalled
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("cfg request stalled");

endmodule

bind zoomed_tilemap_pixel_renderer ztpr_checker u_ztpr_checker (.*);
